[rtl/core/smh_pkg.sv]
// Shared types, constants and round functions of the SHA-256 message hasher.
// Depends on nothing; used by sha256_message_hash.
package smh_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LEN_START     = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [5:0] LAST_BYTE     = 6'd63;
    localparam logic [5:0] SCHED_ROUNDS  = 6'd16;
    localparam logic [3:0] LAST_WORD     = 4'd15;
    localparam logic [3:0] LEN_HI_WORD   = 4'd14;
    localparam logic [3:0] LEN_LO_WORD   = 4'd15;
    localparam logic [2:0] LAST_DIGEST   = 3'd7;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round constant table
    function automatic logic [31:0] round_k(input logic [5:0] r);
        case (r)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

[rtl/core/sha256_message_hash.sv]
// SHA-256 over a byte stream: word-wide block memory, one round per cycle, digest out.
// Each byte is absorbed in IDLE; the 64th byte of a block starts a compression (load, 64 rounds,
// hash update) in the single shared round unit. An end request adds, for each padded
// block (one or two), up to 16 padding words written into the block memory and a
// compression, then 8 digest words at one per cycle of m_tready. Input is held off meanwhile.
// Synchronous active-low reset clears control, counters and the hash; the block memory is
// not cleared (only entries written for the current block are read).
module sha256_message_hash (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic        m_tlast    // last_word
);

    smh_pkg::state_t state_reg, state_next;

    logic [5:0]  bytes_reg, bytes_next;
    logic [63:0] bits_reg, bits_next;
    logic [23:0] acc_reg, acc_next;
    logic [5:0]  round_reg, round_next;
    logic [3:0]  pad_word_reg, pad_word_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_blk_reg, len_blk_next;
    logic        pad_act_reg, pad_act_next;
    logic        end_pend_reg, end_pend_next;
    logic [2:0]  emit_idx_reg, emit_idx_next;

    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];

    // Block memory: one 32-bit big-endian word per entry
    logic [31:0] blk_mem [16];
    logic [31:0] mem_rdata;
    logic [3:0]  mem_raddr;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic        mem_we;

    logic        accept;
    logic        take_byte;
    logic        emit_done;
    logic [5:0]  pad_src;
    logic [31:0] marked_word;
    logic [31:0] pad_value;
    logic [31:0] wt;
    logic [31:0] t1;
    logic [31:0] t2;

    assign s_tready  = (state_reg == smh_pkg::ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign take_byte = accept & s_tuser;
    assign emit_done = m_tvalid & m_tready & m_tlast;

    // Result channel straight from the hash registers
    assign m_tvalid = (state_reg == smh_pkg::ST_EMIT);
    assign m_tdata  = {5'b0, emit_idx_reg, hash_reg[emit_idx_reg]};
    assign m_tlast  = (emit_idx_reg == smh_pkg::LAST_DIGEST);

    // Padding word: held bytes of the partial word, then the marker, then zeros
    assign marked_word = {acc_reg, smh_pkg::PAD_MARK} << {2'd3 - bytes_reg[1:0], 3'b000};

    always_comb begin
        if (pad_first_reg) begin
            pad_value = marked_word;
        end else if (len_blk_reg && pad_word_reg == smh_pkg::LEN_HI_WORD) begin
            pad_value = bits_reg[63:32];
        end else if (len_blk_reg && pad_word_reg == smh_pkg::LEN_LO_WORD) begin
            pad_value = bits_reg[31:0];
        end else begin
            pad_value = 32'h0;
        end
    end

    // Round datapath: message word from memory for the first 16 rounds, else the schedule
    always_comb begin
        if (round_reg < smh_pkg::SCHED_ROUNDS) begin
            wt = mem_rdata;
        end else begin
            wt = smh_pkg::small_sigma1(w_reg[14]) + w_reg[9]
               + smh_pkg::small_sigma0(w_reg[1]) + w_reg[0];
        end
        t1 = v_reg[7] + smh_pkg::big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + smh_pkg::round_k(round_reg) + wt;
        t2 = smh_pkg::big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Prefetch the word for the next round
    assign mem_raddr = (state_reg == smh_pkg::ST_LOAD) ? 4'd0 : round_reg[3:0] + 4'd1;

    // Next state, counters and memory writes
    always_comb begin
        state_next     = state_reg;
        bytes_next     = bytes_reg;
        bits_next      = bits_reg;
        acc_next       = acc_reg;
        round_next     = round_reg;
        pad_word_next  = pad_word_reg;
        pad_first_next = pad_first_reg;
        len_blk_next   = len_blk_reg;
        pad_act_next   = pad_act_reg;
        end_pend_next  = end_pend_reg;
        emit_idx_next  = emit_idx_reg;
        mem_we         = 1'b0;
        mem_waddr      = pad_word_reg;
        mem_wdata      = pad_value;
        pad_src        = bytes_reg;

        case (state_reg)
            smh_pkg::ST_IDLE: begin
                if (accept) begin
                    // absorb the byte; a full word goes to memory
                    if (take_byte) begin
                        bytes_next = bytes_reg + 6'd1;
                        bits_next  = bits_reg + 64'd8;
                        acc_next   = {acc_reg[15:0], s_tdata};
                        if (bytes_reg[1:0] == 2'b11) begin
                            mem_we    = 1'b1;
                            mem_waddr = bytes_reg[5:2];
                            mem_wdata = {acc_reg, s_tdata};
                        end
                    end
                    pad_src = bytes_next;
                    if (take_byte && bytes_reg == smh_pkg::LAST_BYTE) begin
                        end_pend_next = s_tlast;
                        state_next    = smh_pkg::ST_LOAD;
                    end else if (s_tlast) begin
                        pad_word_next  = pad_src[5:2];
                        pad_first_next = 1'b1;
                        len_blk_next   = (pad_src < smh_pkg::LEN_START);
                        pad_act_next   = 1'b1;
                        state_next     = smh_pkg::ST_PAD;
                    end
                end
            end
            smh_pkg::ST_PAD: begin
                mem_we         = 1'b1;
                pad_first_next = 1'b0;
                pad_word_next  = pad_word_reg + 4'd1;
                if (pad_word_reg == smh_pkg::LAST_WORD) begin
                    state_next = smh_pkg::ST_LOAD;
                end
            end
            smh_pkg::ST_LOAD: begin
                round_next = 6'd0;
                state_next = smh_pkg::ST_ROUND;
            end
            smh_pkg::ST_ROUND: begin
                round_next = round_reg + 6'd1;
                if (round_reg == smh_pkg::LAST_ROUND) begin
                    state_next = smh_pkg::ST_UPDATE;
                end
            end
            smh_pkg::ST_UPDATE: begin
                // decide what follows the block just compressed
                if (pad_act_reg && len_blk_reg) begin
                    emit_idx_next = 3'd0;
                    state_next    = smh_pkg::ST_EMIT;
                end else if (pad_act_reg) begin
                    len_blk_next  = 1'b1;
                    pad_word_next = 4'd0;
                    state_next    = smh_pkg::ST_PAD;
                end else if (end_pend_reg) begin
                    end_pend_next  = 1'b0;
                    pad_word_next  = pad_src[5:2];
                    pad_first_next = 1'b1;
                    len_blk_next   = (pad_src < smh_pkg::LEN_START);
                    pad_act_next   = 1'b1;
                    state_next     = smh_pkg::ST_PAD;
                end else begin
                    state_next = smh_pkg::ST_IDLE;
                end
            end
            smh_pkg::ST_EMIT: begin
                if (m_tready) begin
                    emit_idx_next = emit_idx_reg + 3'd1;
                    if (emit_idx_reg == smh_pkg::LAST_DIGEST) begin
                        bytes_next    = 6'd0;
                        bits_next     = 64'd0;
                        pad_act_next  = 1'b0;
                        len_blk_next  = 1'b0;
                        end_pend_next = 1'b0;
                        state_next    = smh_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = smh_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= smh_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg     <= 6'd0;
            bits_reg      <= 64'd0;
            round_reg     <= 6'd0;
            pad_word_reg  <= 4'd0;
            pad_first_reg <= 1'b0;
            len_blk_reg   <= 1'b0;
            pad_act_reg   <= 1'b0;
            end_pend_reg  <= 1'b0;
            emit_idx_reg  <= 3'd0;
        end else begin
            bytes_reg     <= bytes_next;
            bits_reg      <= bits_next;
            round_reg     <= round_next;
            pad_word_reg  <= pad_word_next;
            pad_first_reg <= pad_first_next;
            len_blk_reg   <= len_blk_next;
            pad_act_reg   <= pad_act_next;
            end_pend_reg  <= end_pend_next;
            emit_idx_reg  <= emit_idx_next;
        end
    end

    // Partial-word byte holder
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // Chaining hash: initial value, add after each block, reload after the digest
    always_ff @(posedge aclk) begin
        if (!aresetn || emit_done) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= smh_pkg::HASH_INIT[i];
            end
        end else if (state_reg == smh_pkg::ST_UPDATE) begin
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
        end
    end

    // Working variables and schedule window
    always_ff @(posedge aclk) begin
        if (state_reg == smh_pkg::ST_LOAD) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= hash_reg[i];
            end
        end else if (state_reg == smh_pkg::ST_ROUND) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wt;
        end
    end

    // Block memory write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            blk_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= blk_mem[mem_raddr];
    end

    // The block memory is only written outside compression
    a_no_write_in_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smh_pkg::ST_ROUND || state_reg == smh_pkg::ST_LOAD) |-> !mem_we)
        else $error("block memory written during compression");

    // Input and result sides never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while digest is out");

    // The last round hands over to the hash update
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smh_pkg::ST_ROUND && round_reg == smh_pkg::LAST_ROUND)
        |=> state_reg == smh_pkg::ST_UPDATE)
        else $error("compression did not end after the last round");

    // After the final digest word, a fresh message starts empty
    a_fresh_message: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_done |=> (s_tready && bytes_reg == 6'd0 && bits_reg == 64'd0 && !pad_act_reg))
        else $error("message state not cleared after digest");

    // The digest only comes after a length-carrying block
    a_emit_after_len: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (pad_act_reg && len_blk_reg))
        else $error("digest emitted before the length block");

endmodule
